// File: rtl/psda_pkg.sv
// Shared constants for the point scatter difference accumulator.
`timescale 1ns / 1ps

package psda_pkg;

   localparam int IMG_ROWS  = 1024;
   localparam int IMG_COLS  = 512;
   localparam int PIX_COUNT = IMG_ROWS * IMG_COLS;
   localparam int ADDR_W    = $clog2(PIX_COUNT);

   // Entry layout: {red, green, blue, last level low byte, last color}
   localparam int ENTRY_W   = 40;

   localparam logic KIND_ACCUM   = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_MODIFY = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;

endpackage

// File: rtl/point_scatter_difference_accumulator_unit.sv
// Per-pixel difference accumulator: one pixel memory, read, modify and write back.
//
//   channel   | ports                                                  | handshake
//   ----------+--------------------------------------------------------+----------------------
//   request   | req_kind req_pixel_row req_pixel_col req_point_color   | start & !busy
//             | req_depth_level                                        |
//   result    | rsp_chan_blue rsp_chan_green rsp_chan_red              | rsp_valid, one cycle
//
// An item passes a read state, which reads the pixel entry from the single-port-read
// memory, and a modify state, which updates it (a readout clears it) and writes it back;
// the next beat is taken in the modify state. A readout gives its result in the cycle after it.
// After reset the block sweeps the whole memory to zero, one entry a cycle:
// PIX_COUNT entries (524288 at 1024 x 512), with busy high all the while.
// The result side cannot stall; rsp_valid is a single-cycle strobe.
`timescale 1ns / 1ps

module point_scatter_difference_accumulator_unit
   import psda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [9:0] req_pixel_row,
   input  logic [8:0] req_pixel_col,
   input  logic [7:0] req_point_color,
   input  logic [9:0] req_depth_level,
   output logic       rsp_valid,
   output logic [7:0] rsp_chan_blue,
   output logic [7:0] rsp_chan_green,
   output logic [7:0] rsp_chan_red
);

   logic [1:0]         state_ff, state_in;
   addr_type           clr_cnt_ff, clr_cnt_in;

   logic               kind_ff;
   logic               inside_ff;
   addr_type           addr_ff;
   logic [7:0]         color_ff;
   logic [9:0]         level_ff;

   logic [ENTRY_W-1:0] mem [PIX_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               wr_en;
   addr_type           wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic               accept;
   logic               req_inside;
   addr_type           req_addr;

   logic [7:0]         acc_blue, acc_green, acc_red;
   logic [7:0]         prev_color, prev_level;
   logic [9:0]         prev_level_ext;
   logic [9:0]         level_diff;
   logic [7:0]         new_blue, new_green, new_red;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_blue_ff, rsp_green_ff, rsp_red_ff;

   assign busy   = (state_ff == ST_CLEAR) || (state_ff == ST_READ);
   assign accept = start && !busy;

   assign req_inside = (32'(req_pixel_row) < IMG_ROWS) && (32'(req_pixel_col) < IMG_COLS);
   assign req_addr   = ADDR_W'(ADDR_W'(req_pixel_row) * ADDR_W'(IMG_COLS))
                       + ADDR_W'(req_pixel_col);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (32'(clr_cnt_ff) == PIX_COUNT - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = accept ? ST_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Hold the beat for the read and modify cycles
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         inside_ff <= req_inside;
         addr_ff   <= req_addr;
         color_ff  <= req_point_color;
         level_ff  <= req_depth_level;
      end
   end

   // Update arithmetic on the entry read back
   assign acc_blue       = rd_data_ff[23:16];
   assign acc_green      = rd_data_ff[31:24];
   assign acc_red        = rd_data_ff[39:32];
   assign prev_color     = rd_data_ff[7:0];
   assign prev_level     = rd_data_ff[15:8];
   assign prev_level_ext = {2'b00, prev_level};
   assign level_diff     = (level_ff >= prev_level_ext) ? (level_ff - prev_level_ext)
                                                        : (prev_level_ext - level_ff);
   assign new_blue       = acc_blue + color_ff - prev_color;
   assign new_green      = acc_green + level_diff[7:0];
   assign new_red        = acc_red + {7'd0, (level_ff != prev_level_ext)};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (state_ff == ST_MODIFY && inside_ff) begin
         wr_en = 1'b1;
         if (kind_ff == KIND_ACCUM) begin
            wr_data = {new_red, new_green, new_blue, level_ff[7:0], color_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_MODIFY) && (kind_ff == KIND_READOUT);
      end
   end

   // Drop the stored sums for pixels outside the image
   always_ff @(posedge clock) begin
      if (state_ff == ST_MODIFY) begin
         rsp_blue_ff  <= inside_ff ? acc_blue  : 8'd0;
         rsp_green_ff <= inside_ff ? acc_green : 8'd0;
         rsp_red_ff   <= inside_ff ? acc_red   : 8'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chan_blue  = rsp_blue_ff;
   assign rsp_chan_green = rsp_green_ff;
   assign rsp_chan_red   = rsp_red_ff;

   a_read_then_modify: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_MODIFY)
      else $error("read cycle not followed by modify cycle");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid)
      else $error("result strobe during clearing sweep");

   a_rsp_after_modify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_MODIFY && $past(kind_ff) == KIND_READOUT)
      else $error("result strobe without a readout beat");

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted beat did not start a read");

   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !wr_en)
      else $error("memory written during read cycle");

endmodule
